// ===== rtl/core/crc16_framed_packet_parser_defines.svh =====
// assertion macros shared by the frame parser modules
// expects clk and rst_n in the scope where a macro is used
`ifndef CRC16_FRAMED_PACKET_PARSER_DEFINES_SVH
`define CRC16_FRAMED_PACKET_PARSER_DEFINES_SVH

// same-cycle implication
`define CFPP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CFPP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/cfpp_pkg.sv =====
// shared types and constants of the crc16 framed packet parser
// used by cfpp_ctrl, cfpp_dp and the top level; no dependencies
`default_nettype none

package cfpp_pkg;

    localparam int MAX_PAYLOAD_DEF = 64;
    localparam int LEN_W           = 7;
    localparam int IDX_W           = 6;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 16;

    // result event codes
    localparam logic [2:0] EV_NONE     = 3'd0;
    localparam logic [2:0] EV_BAD_SYNC = 3'd1;
    localparam logic [2:0] EV_BAD_VER  = 3'd2;
    localparam logic [2:0] EV_BAD_LEN  = 3'd3;
    localparam logic [2:0] EV_FRAME_OK = 3'd4;
    localparam logic [2:0] EV_BAD_CRC  = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VERSION     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CRC_POLY    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CRC_INIT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CRC_REFLECT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CRC_XOROUT  = 3'd6;

    localparam logic [7:0]  SYNC_FIRST_RST  = 8'hAA;
    localparam logic [7:0]  SYNC_SECOND_RST = 8'h55;
    localparam logic [7:0]  VERSION_RST     = 8'h01;
    localparam logic [15:0] CRC_POLY_RST    = 16'h1021;
    localparam logic [15:0] CRC_INIT_RST    = 16'hFFFF;
    localparam logic        CRC_REFLECT_RST = 1'b0;
    localparam logic [15:0] CRC_XOROUT_RST  = 16'h0000;

    // controller to datapath
    typedef struct packed {
        logic       take_byte;
        logic       crc_init_load;
        logic       crc_feed;
        logic       hold_seq;
        logic       hold_type;
        logic       hold_len;
        logic       count_clear;
        logic       pay_write;
        logic       crc_lo_load;
        logic       frame_ok;
        logic       emit;
        logic [2:0] emit_ev;
        logic       rd_start;
        logic       rd_issue;
        logic       rd_emit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic eq_sync1;
        logic eq_sync2;
        logic eq_ver;
        logic len_over;
        logic byte_zero;
        logic held_zero;
        logic pay_done;
        logic crc_ok;
        logic out_free;
        logic rd_last;
    } sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/cfpp_ctrl.sv =====
// parser controller: transfer sequencing, frame phase tracking, read-out sequencing
// depends on cfpp_pkg and crc16_framed_packet_parser_defines.svh
`default_nettype none
`include "crc16_framed_packet_parser_defines.svh"

module cfpp_ctrl
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         rx_valid,
    output logic              rx_stall,
    input  cfpp_pkg::sts_t    sts,
    output cfpp_pkg::cmd_t    cmd
);

    localparam logic [1:0] ST_WAIT    = 2'd0;
    localparam logic [1:0] ST_STEP    = 2'd1;
    localparam logic [1:0] ST_RD_ADDR = 2'd2;
    localparam logic [1:0] ST_RD_EMIT = 2'd3;

    localparam logic [3:0] PH_SYNC1 = 4'd0;
    localparam logic [3:0] PH_SYNC2 = 4'd1;
    localparam logic [3:0] PH_VER   = 4'd2;
    localparam logic [3:0] PH_SEQ   = 4'd3;
    localparam logic [3:0] PH_TYPE  = 4'd4;
    localparam logic [3:0] PH_LEN   = 4'd5;
    localparam logic [3:0] PH_PAY   = 4'd6;
    localparam logic [3:0] PH_CRCLO = 4'd7;
    localparam logic [3:0] PH_CRCHI = 4'd8;

    logic [1:0]     state_reg, state_next;
    logic [3:0]     phase_reg, phase_next;
    logic [1:0]     step_state;
    logic [3:0]     step_phase;
    logic           need_out;
    cfpp_pkg::cmd_t step_cmd;

    assign rx_stall = (state_reg != ST_WAIT);

    always_comb
    begin
        cmd        = '0;
        step_cmd   = '0;
        state_next = state_reg;
        phase_next = phase_reg;
        step_state = ST_WAIT;
        step_phase = phase_reg;
        need_out   = 1'b0;
        case (state_reg)
            ST_WAIT:
            begin
                if (rx_valid)
                begin
                    cmd.take_byte = 1'b1;
                    state_next    = ST_STEP;
                end
            end
            ST_STEP:
            begin
                case (phase_reg)
                    PH_SYNC2:
                    begin
                        if (sts.eq_sync2)
                        begin
                            step_phase = PH_VER;
                        end
                        else
                        begin
                            // a repeated first sync byte keeps the hunt one byte in
                            step_phase       = sts.eq_sync1 ? PH_SYNC2 : PH_SYNC1;
                            need_out         = 1'b1;
                            step_cmd.emit    = 1'b1;
                            step_cmd.emit_ev = cfpp_pkg::EV_BAD_SYNC;
                        end
                    end
                    PH_VER:
                    begin
                        if (!sts.eq_ver)
                        begin
                            step_phase       = PH_SYNC1;
                            need_out         = 1'b1;
                            step_cmd.emit    = 1'b1;
                            step_cmd.emit_ev = cfpp_pkg::EV_BAD_VER;
                        end
                        else
                        begin
                            step_cmd.crc_init_load = 1'b1;
                            step_cmd.crc_feed      = 1'b1;
                            step_phase             = PH_SEQ;
                        end
                    end
                    PH_SEQ:
                    begin
                        step_cmd.hold_seq = 1'b1;
                        step_cmd.crc_feed = 1'b1;
                        step_phase        = PH_TYPE;
                    end
                    PH_TYPE:
                    begin
                        step_cmd.hold_type = 1'b1;
                        step_cmd.crc_feed  = 1'b1;
                        step_phase         = PH_LEN;
                    end
                    PH_LEN:
                    begin
                        if (sts.len_over)
                        begin
                            step_phase       = PH_SYNC1;
                            need_out         = 1'b1;
                            step_cmd.emit    = 1'b1;
                            step_cmd.emit_ev = cfpp_pkg::EV_BAD_LEN;
                        end
                        else
                        begin
                            step_cmd.hold_len    = 1'b1;
                            step_cmd.crc_feed    = 1'b1;
                            step_cmd.count_clear = 1'b1;
                            step_phase           = sts.byte_zero ? PH_CRCLO : PH_PAY;
                        end
                    end
                    PH_PAY:
                    begin
                        step_cmd.pay_write = 1'b1;
                        step_cmd.crc_feed  = 1'b1;
                        if (sts.pay_done)
                        begin
                            step_phase = PH_CRCLO;
                        end
                    end
                    PH_CRCLO:
                    begin
                        step_cmd.crc_lo_load = 1'b1;
                        step_phase           = PH_CRCHI;
                    end
                    PH_CRCHI:
                    begin
                        step_phase = PH_SYNC1;
                        if (!sts.crc_ok)
                        begin
                            need_out         = 1'b1;
                            step_cmd.emit    = 1'b1;
                            step_cmd.emit_ev = cfpp_pkg::EV_BAD_CRC;
                        end
                        else
                        begin
                            step_cmd.frame_ok = 1'b1;
                            if (sts.held_zero)
                            begin
                                need_out         = 1'b1;
                                step_cmd.emit    = 1'b1;
                                step_cmd.emit_ev = cfpp_pkg::EV_FRAME_OK;
                            end
                            else
                            begin
                                step_cmd.rd_start = 1'b1;
                                step_state        = ST_RD_ADDR;
                            end
                        end
                    end
                    default:
                    begin
                        step_phase = sts.eq_sync1 ? PH_SYNC2 : PH_SYNC1;
                    end
                endcase
                // hold the step until the output register can take its result
                if (!need_out || sts.out_free)
                begin
                    cmd        = step_cmd;
                    phase_next = step_phase;
                    state_next = step_state;
                end
            end
            ST_RD_ADDR:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_RD_EMIT;
            end
            ST_RD_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.rd_emit = 1'b1;
                    state_next  = sts.rd_last ? ST_WAIT : ST_RD_ADDR;
                end
            end
            default:
            begin
                state_next = ST_WAIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_WAIT;
            phase_reg <= PH_SYNC1;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    `CFPP_ASSERT_NEXT(a_take_then_step, (state_reg == ST_WAIT) && rx_valid, state_reg == ST_STEP, "accepted byte not followed by a parse step")
    `CFPP_ASSERT_NOW(a_emit_when_free, cmd.emit || cmd.rd_emit, sts.out_free, "result loaded into a busy output register")
    `CFPP_ASSERT_NOW(a_readout_from_crc, cmd.rd_start, (phase_reg == PH_CRCHI) && sts.crc_ok, "read-out started outside a good crc check")

endmodule

`default_nettype wire

// ===== rtl/core/cfpp_dp.sv =====
// parser datapath: config registers, byte-wide crc unit, frame header holding,
// payload memory, sequence gap tracking and the result register; depends on cfpp_pkg
`default_nettype none
`include "crc16_framed_packet_parser_defines.svh"

module cfpp_dp
#(
    parameter int MAX_PAYLOAD = cfpp_pkg::MAX_PAYLOAD_DEF
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    input  wire logic [cfpp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [cfpp_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic [7:0]                        rx_byte,
    input  cfpp_pkg::cmd_t                         cmd,
    output cfpp_pkg::sts_t                         sts,
    output logic                                   res_valid,
    input  wire logic                              res_stall,
    output logic [2:0]                             event_res,
    output logic [7:0]                             frame_type,
    output logic [7:0]                             frame_seq,
    output logic [cfpp_pkg::LEN_W-1:0]             frame_len,
    output logic                                   data_valid,
    output logic [7:0]                             data_byte,
    output logic [cfpp_pkg::IDX_W-1:0]             data_index,
    output logic                                   gap_flag,
    output logic [7:0]                             seq_gap,
    output logic                                   last
);

    localparam int AW    = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int LEN_W = cfpp_pkg::LEN_W;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b,
                                             input logic [15:0] poly);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            c = c[15] ? ({c[14:0], 1'b0} ^ poly) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    function automatic logic [7:0] rev8(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++)
        begin
            r[i] = v[7-i];
        end
        return r;
    endfunction

    function automatic logic [15:0] rev16(input logic [15:0] v);
        logic [15:0] r;
        for (int i = 0; i < 16; i++)
        begin
            r[i] = v[15-i];
        end
        return r;
    endfunction

    // configuration
    logic [7:0]  sync_first_reg, sync_second_reg, version_reg;
    logic [15:0] crc_poly_reg, crc_init_reg, crc_xorout_reg;
    logic        crc_reflect_reg;

    // frame state
    logic [7:0]       byte_reg;
    logic [15:0]      crc_reg;
    logic [7:0]       held_seq_reg, held_type_reg;
    logic [LEN_W-1:0] held_len_reg;
    logic [LEN_W-1:0] count_reg;
    logic [7:0]       crc_lo_reg;
    logic [7:0]       prev_seq_reg;
    logic             prev_valid_reg;
    logic             gap_flag_reg;
    logic [7:0]       seq_gap_reg;
    logic [LEN_W-1:0] rd_idx_reg;
    logic [7:0]       mem_q_reg;
    logic [7:0]       mem [MAX_PAYLOAD];

    // result register
    logic                              res_valid_reg;
    logic [2:0]                        ev_reg;
    logic [7:0]                        type_out_reg, seq_out_reg;
    logic [LEN_W-1:0]                  len_out_reg;
    logic                              dv_out_reg;
    logic [7:0]                        db_out_reg;
    logic [cfpp_pkg::IDX_W-1:0]        di_out_reg;
    logic                              gf_out_reg;
    logic [7:0]                        gap_out_reg;
    logic                              last_out_reg;

    logic [7:0]  feed_byte;
    logic [15:0] crc_base, crc_calc;
    logic [15:0] crc_check;
    logic [7:0]  seq_expect;
    logic        gf_now;
    logic [7:0]  gap_now;
    logic [LEN_W:0] count_inc, rd_inc;

    assign feed_byte  = crc_reflect_reg ? rev8(byte_reg) : byte_reg;
    assign crc_base   = cmd.crc_init_load ? crc_init_reg : crc_reg;
    assign crc_calc   = crc_byte(crc_base, feed_byte, crc_poly_reg);
    assign crc_check  = (crc_reflect_reg ? rev16(crc_reg) : crc_reg) ^ crc_xorout_reg;
    assign seq_expect = prev_seq_reg + 8'd1;
    assign gf_now     = prev_valid_reg && (held_seq_reg != seq_expect);
    assign gap_now    = gf_now ? (held_seq_reg - seq_expect) : 8'd0;
    assign count_inc  = {1'b0, count_reg} + 1'b1;
    assign rd_inc     = {1'b0, rd_idx_reg} + 1'b1;

    always_comb
    begin
        sts.eq_sync1  = (byte_reg == sync_first_reg);
        sts.eq_sync2  = (byte_reg == sync_second_reg);
        sts.eq_ver    = (byte_reg == version_reg);
        sts.len_over  = (byte_reg > 8'(MAX_PAYLOAD));
        sts.byte_zero = (byte_reg == 8'd0);
        sts.held_zero = (held_len_reg == '0);
        sts.pay_done  = (count_inc >= {1'b0, held_len_reg});
        sts.crc_ok    = (crc_check == {byte_reg, crc_lo_reg});
        sts.out_free  = !res_valid_reg || !res_stall;
        sts.rd_last   = (rd_inc == {1'b0, held_len_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg  <= cfpp_pkg::SYNC_FIRST_RST;
            sync_second_reg <= cfpp_pkg::SYNC_SECOND_RST;
            version_reg     <= cfpp_pkg::VERSION_RST;
            crc_poly_reg    <= cfpp_pkg::CRC_POLY_RST;
            crc_init_reg    <= cfpp_pkg::CRC_INIT_RST;
            crc_reflect_reg <= cfpp_pkg::CRC_REFLECT_RST;
            crc_xorout_reg  <= cfpp_pkg::CRC_XOROUT_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                cfpp_pkg::CFG_SYNC_FIRST:  sync_first_reg  <= cfg_data[7:0];
                cfpp_pkg::CFG_SYNC_SECOND: sync_second_reg <= cfg_data[7:0];
                cfpp_pkg::CFG_VERSION:     version_reg     <= cfg_data[7:0];
                cfpp_pkg::CFG_CRC_POLY:    crc_poly_reg    <= cfg_data;
                cfpp_pkg::CFG_CRC_INIT:    crc_init_reg    <= cfg_data;
                cfpp_pkg::CFG_CRC_REFLECT: crc_reflect_reg <= cfg_data[0];
                cfpp_pkg::CFG_CRC_XOROUT:  crc_xorout_reg  <= cfg_data;
                default:                   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg        <= '0;
            held_seq_reg   <= '0;
            held_type_reg  <= '0;
            held_len_reg   <= '0;
            count_reg      <= '0;
            crc_lo_reg     <= '0;
            prev_seq_reg   <= '0;
            prev_valid_reg <= 1'b0;
            gap_flag_reg   <= 1'b0;
            seq_gap_reg    <= '0;
            rd_idx_reg     <= '0;
        end
        else
        begin
            if (cmd.crc_feed)
            begin
                crc_reg <= crc_calc;
            end
            if (cmd.hold_seq)
            begin
                held_seq_reg <= byte_reg;
            end
            if (cmd.hold_type)
            begin
                held_type_reg <= byte_reg;
            end
            if (cmd.hold_len)
            begin
                held_len_reg <= byte_reg[LEN_W-1:0];
            end
            if (cmd.count_clear)
            begin
                count_reg <= '0;
            end
            else if (cmd.pay_write)
            begin
                count_reg <= count_inc[LEN_W-1:0];
            end
            if (cmd.crc_lo_load)
            begin
                crc_lo_reg <= byte_reg;
            end
            if (cmd.frame_ok)
            begin
                prev_seq_reg   <= held_seq_reg;
                prev_valid_reg <= 1'b1;
                gap_flag_reg   <= gf_now;
                seq_gap_reg    <= gap_now;
            end
            if (cmd.rd_start)
            begin
                rd_idx_reg <= '0;
            end
            else if (cmd.rd_emit)
            begin
                rd_idx_reg <= rd_inc[LEN_W-1:0];
            end
        end
    end

    // byte register and payload memory carry no reset
    always_ff @(posedge clk)
    begin
        if (cmd.take_byte)
        begin
            byte_reg <= rx_byte;
        end
        if (cmd.pay_write)
        begin
            mem[count_reg[AW-1:0]] <= byte_reg;
        end
        if (cmd.rd_issue)
        begin
            mem_q_reg <= mem[rd_idx_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (cmd.emit || cmd.rd_emit)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            ev_reg       <= cmd.emit_ev;
            dv_out_reg   <= 1'b0;
            db_out_reg   <= '0;
            di_out_reg   <= '0;
            last_out_reg <= 1'b1;
            // header fields only for frame-level events
            if ((cmd.emit_ev == cfpp_pkg::EV_FRAME_OK) || (cmd.emit_ev == cfpp_pkg::EV_BAD_CRC))
            begin
                type_out_reg <= held_type_reg;
                seq_out_reg  <= held_seq_reg;
                len_out_reg  <= held_len_reg;
            end
            else
            begin
                type_out_reg <= '0;
                seq_out_reg  <= '0;
                len_out_reg  <= '0;
            end
            if (cmd.emit_ev == cfpp_pkg::EV_FRAME_OK)
            begin
                gf_out_reg  <= gf_now;
                gap_out_reg <= gap_now;
            end
            else
            begin
                gf_out_reg  <= 1'b0;
                gap_out_reg <= '0;
            end
        end
        else if (cmd.rd_emit)
        begin
            ev_reg       <= cfpp_pkg::EV_FRAME_OK;
            type_out_reg <= held_type_reg;
            seq_out_reg  <= held_seq_reg;
            len_out_reg  <= held_len_reg;
            dv_out_reg   <= 1'b1;
            db_out_reg   <= mem_q_reg;
            di_out_reg   <= rd_idx_reg[cfpp_pkg::IDX_W-1:0];
            gf_out_reg   <= gap_flag_reg;
            gap_out_reg  <= seq_gap_reg;
            last_out_reg <= sts.rd_last;
        end
    end

    assign res_valid  = res_valid_reg;
    assign event_res  = ev_reg;
    assign frame_type = type_out_reg;
    assign frame_seq  = seq_out_reg;
    assign frame_len  = len_out_reg;
    assign data_valid = dv_out_reg;
    assign data_byte  = db_out_reg;
    assign data_index = di_out_reg;
    assign gap_flag   = gf_out_reg;
    assign seq_gap    = gap_out_reg;
    assign last       = last_out_reg;

    `CFPP_ASSERT_NOW(a_store_in_range, cmd.pay_write, count_reg < LEN_W'(MAX_PAYLOAD), "payload write beyond the store")
    `CFPP_ASSERT_NOW(a_read_in_frame, cmd.rd_issue, rd_idx_reg < held_len_reg, "payload read beyond the frame length")
    `CFPP_ASSERT_NEXT(a_result_held, res_valid_reg && res_stall, res_valid_reg && $stable(ev_reg) && $stable(db_out_reg), "stalled result changed")

endmodule

`default_nettype wire

// ===== rtl/core/crc16_framed_packet_parser.sv =====
// top level of the crc16 framed packet parser: controller plus datapath
// depends on cfpp_pkg, cfpp_ctrl and cfpp_dp
//
//   channel   handshake              payload
//   rx        rx_valid / rx_stall    rx_byte
//   result    res_valid / res_stall  event_res .. last (ten fields)
//   config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// each received byte is taken into the byte register and then goes through the parse step
// with the byte-wide crc update; the next byte is not taken until that step is done
// a good frame is read out byte by byte through the payload memory's registered read port
// into the result register; no byte is taken during read-out
// a result held by res_stall holds the read-out, or a parse step with a result, where it stands
// reset is asynchronous; the payload memory is not cleared and needs no clearing pass
`default_nettype none

module crc16_framed_packet_parser
#(
    parameter int MAX_PAYLOAD = cfpp_pkg::MAX_PAYLOAD_DEF
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              rx_valid,
    output logic                                   rx_stall,
    input  wire logic [7:0]                        rx_byte,
    output logic                                   res_valid,
    input  wire logic                              res_stall,
    output logic [2:0]                             event_res,
    output logic [7:0]                             frame_type,
    output logic [7:0]                             frame_seq,
    output logic [cfpp_pkg::LEN_W-1:0]             frame_len,
    output logic                                   data_valid,
    output logic [7:0]                             data_byte,
    output logic [cfpp_pkg::IDX_W-1:0]             data_index,
    output logic                                   gap_flag,
    output logic [7:0]                             seq_gap,
    output logic                                   last,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [cfpp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [cfpp_pkg::CFG_DATA_W-1:0]   cfg_data
);

    cfpp_pkg::cmd_t cmd;
    cfpp_pkg::sts_t sts;

    // registers are to be written only while the parser is idle; the block itself does not enforce this
    assign cfg_ready = 1'b1;

    cfpp_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_valid (rx_valid),
        .rx_stall (rx_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    cfpp_dp
    #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    )
    u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .rx_byte    (rx_byte),
        .cmd        (cmd),
        .sts        (sts),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .event_res  (event_res),
        .frame_type (frame_type),
        .frame_seq  (frame_seq),
        .frame_len  (frame_len),
        .data_valid (data_valid),
        .data_byte  (data_byte),
        .data_index (data_index),
        .gap_flag   (gap_flag),
        .seq_gap    (seq_gap),
        .last       (last)
    );

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// self-checking bench for crc16_framed_packet_parser: frame builder, byte-level predictor
// and result checker; depends on cfpp_pkg and the parser rtl
`timescale 1ns / 100ps

typedef struct packed {
    logic [2:0] ev;
    logic [7:0] ftype;
    logic [7:0] seq;
    logic [6:0] len;
    logic       dv;
    logic [7:0] dbyte;
    logic [5:0] didx;
    logic       gflag;
    logic [7:0] gap;
    logic       lst;
} frame_result_t;

typedef enum logic [3:0] {
    ST_HUNT, ST_SYNC2, ST_VERSION, ST_SEQ, ST_TYPE, ST_LEN, ST_PAYLOAD, ST_CRC_LO, ST_CRC_HI
} deframe_state_e;

class frame_checker;
    localparam int MAX_LEN  = cfpp_pkg::MAX_PAYLOAD_DEF;
    localparam int SHOW_MAX = 40;

    // register copies
    logic [7:0]  sync_a, sync_b, version;
    logic [15:0] poly, init_val, xorout;
    logic        reflect;

    // parser state
    deframe_state_e state;
    logic [15:0]    crc;
    logic [7:0]     seq, ftype, crc_lo, last_seq;
    logic [6:0]     len, count;
    logic           last_seq_ok;
    logic [7:0]     payload [MAX_LEN];

    frame_result_t results_due [$];
    int errors;
    int checked;

    function new();
        sync_a      = cfpp_pkg::SYNC_FIRST_RST;
        sync_b      = cfpp_pkg::SYNC_SECOND_RST;
        version     = cfpp_pkg::VERSION_RST;
        poly        = cfpp_pkg::CRC_POLY_RST;
        init_val    = cfpp_pkg::CRC_INIT_RST;
        reflect     = cfpp_pkg::CRC_REFLECT_RST;
        xorout      = cfpp_pkg::CRC_XOROUT_RST;
        state       = ST_HUNT;
        crc         = '0;
        seq         = '0;
        ftype       = '0;
        crc_lo      = '0;
        last_seq    = '0;
        len         = '0;
        count       = '0;
        last_seq_ok = 1'b0;
        errors      = 0;
        checked     = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] data);
        case (idx)
            cfpp_pkg::CFG_SYNC_FIRST:  sync_a   = data[7:0];
            cfpp_pkg::CFG_SYNC_SECOND: sync_b   = data[7:0];
            cfpp_pkg::CFG_VERSION:     version  = data[7:0];
            cfpp_pkg::CFG_CRC_POLY:    poly     = data;
            cfpp_pkg::CFG_CRC_INIT:    init_val = data;
            cfpp_pkg::CFG_CRC_REFLECT: reflect  = data[0];
            cfpp_pkg::CFG_CRC_XOROUT:  xorout   = data;
            default: ;
        endcase
    endfunction

    function logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
        logic [7:0] d;
        for (int i = 0; i < 8; i++)
            d[i] = reflect ? b[7-i] : b[i];
        c = c ^ {d, 8'h00};
        for (int i = 0; i < 8; i++)
            c = c[15] ? ((c << 1) ^ poly) : (c << 1);
        return c;
    endfunction

    function logic [15:0] crc_final(logic [15:0] c);
        logic [15:0] r;
        for (int i = 0; i < 16; i++)
            r[i] = reflect ? c[15-i] : c[i];
        return r ^ xorout;
    endfunction

    // check value as sent on the link for version .. payload
    function logic [15:0] wire_crc(logic [7:0] body [$]);
        logic [15:0] c;
        c = init_val;
        foreach (body[i])
            c = crc_step(c, body[i]);
        return crc_final(c);
    endfunction

    function void add_result(logic [2:0] ev, logic [7:0] ft, logic [7:0] sq, logic [6:0] ln,
                             logic dv, logic [7:0] db, logic [5:0] di, logic gf,
                             logic [7:0] gp, logic lst);
        results_due.push_back({ev, ft, sq, ln, dv, db, di, gf, gp, lst});
    endfunction

    // predicts the results caused by one accepted byte
    function void take_byte(logic [7:0] b);
        logic [15:0] rx_fcs;
        logic [7:0]  next_seq, gap;
        logic        gf;
        case (state)
            ST_SYNC2:
            begin
                if (b == sync_b)
                    state = ST_VERSION;
                else
                begin
                    state = (b == sync_a) ? ST_SYNC2 : ST_HUNT;
                    add_result(cfpp_pkg::EV_BAD_SYNC, 0, 0, 0, 0, 0, 0, 0, 0, 1);
                end
            end
            ST_VERSION:
            begin
                if (b != version)
                begin
                    state = ST_HUNT;
                    count = '0;
                    add_result(cfpp_pkg::EV_BAD_VER, 0, 0, 0, 0, 0, 0, 0, 0, 1);
                end
                else
                begin
                    crc   = crc_step(init_val, b);
                    state = ST_SEQ;
                end
            end
            ST_SEQ:
            begin
                seq   = b;
                crc   = crc_step(crc, b);
                state = ST_TYPE;
            end
            ST_TYPE:
            begin
                ftype = b;
                crc   = crc_step(crc, b);
                state = ST_LEN;
            end
            ST_LEN:
            begin
                if (b > MAX_LEN)
                begin
                    state = ST_HUNT;
                    count = '0;
                    add_result(cfpp_pkg::EV_BAD_LEN, 0, 0, 0, 0, 0, 0, 0, 0, 1);
                end
                else
                begin
                    len   = b[6:0];
                    crc   = crc_step(crc, b);
                    count = '0;
                    state = (b == 8'd0) ? ST_CRC_LO : ST_PAYLOAD;
                end
            end
            ST_PAYLOAD:
            begin
                if (count < MAX_LEN)
                    payload[count] = b;
                crc   = crc_step(crc, b);
                count = count + 7'd1;
                if (count >= len)
                    state = ST_CRC_LO;
            end
            ST_CRC_LO:
            begin
                crc_lo = b;
                state  = ST_CRC_HI;
            end
            ST_CRC_HI:
            begin
                rx_fcs = {b, crc_lo};
                state  = ST_HUNT;
                count  = '0;
                if (crc_final(crc) != rx_fcs)
                    add_result(cfpp_pkg::EV_BAD_CRC, ftype, seq, len, 0, 0, 0, 0, 0, 1);
                else
                begin
                    gf       = 1'b0;
                    gap      = '0;
                    next_seq = last_seq + 8'd1;
                    if (last_seq_ok && seq != next_seq)
                    begin
                        gf  = 1'b1;
                        gap = seq - next_seq;
                    end
                    last_seq    = seq;
                    last_seq_ok = 1'b1;
                    if (len == 0)
                        add_result(cfpp_pkg::EV_FRAME_OK, ftype, seq, 0, 0, 0, 0, gf, gap, 1);
                    else
                        for (int n = 0; n < len && n < MAX_LEN; n++)
                            add_result(cfpp_pkg::EV_FRAME_OK, ftype, seq, len, 1, payload[n],
                                       6'(n), gf, gap, (n + 1 == len));
                end
            end
            default:
                state = (b == sync_a) ? ST_SYNC2 : ST_HUNT;
        endcase
    endfunction

    function void field_diff(string name, longint unsigned want, longint unsigned got);
        if (want != got && errors <= SHOW_MAX)
            $display("%0t: mismatch on %s: expected %0h actual %0h", $time, name, want, got);
    endfunction

    function void match_result(frame_result_t got);
        frame_result_t want;
        if (results_due.size() == 0)
        begin
            errors++;
            if (errors <= SHOW_MAX)
                $display("%0t: result with nothing expected: expected none actual event %0d",
                         $time, got.ev);
            return;
        end
        want = results_due.pop_front();
        checked++;
        if (want != got)
        begin
            errors++;
            field_diff("event_res", want.ev, got.ev);
            field_diff("frame_type", want.ftype, got.ftype);
            field_diff("frame_seq", want.seq, got.seq);
            field_diff("frame_len", want.len, got.len);
            field_diff("data_valid", want.dv, got.dv);
            field_diff("data_byte", want.dbyte, got.dbyte);
            field_diff("data_index", want.didx, got.didx);
            field_diff("gap_flag", want.gflag, got.gflag);
            field_diff("seq_gap", want.gap, got.gap);
            field_diff("last", want.lst, got.lst);
        end
    endfunction
endclass

module tb_top;

    localparam int          IDLE_LIMIT   = 2000;
    localparam int          DRAIN_CYCLES = 12;
    localparam logic [2:0]  CFG_UNUSED   = 3'd7;

    typedef enum int {
        FK_GOOD, FK_BAD_CRC_LO, FK_BAD_CRC_HI, FK_BAD_VER, FK_BAD_LEN,
        FK_BAD_SYNC, FK_SYNC_RETRY, FK_CUT
    } frame_kind_e;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic        rx_valid = 1'b0;
    logic [7:0]  rx_byte = '0;
    logic        res_stall = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [cfpp_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [cfpp_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    logic                       rx_stall;
    logic                       res_valid;
    logic [2:0]                 event_res;
    logic [7:0]                 frame_type;
    logic [7:0]                 frame_seq;
    logic [cfpp_pkg::LEN_W-1:0] frame_len;
    logic                       data_valid;
    logic [7:0]                 data_byte;
    logic [cfpp_pkg::IDX_W-1:0] data_index;
    logic                       gap_flag;
    logic [7:0]                 seq_gap;
    logic                       last;
    logic                       cfg_ready;

    frame_checker chk = new();

    bit         quiet = 1'b0;
    int         idle_cycles = 0;
    int         hold_left = 0;
    int         bytes_sent = 0;
    int         frames_sent = 0;
    int         reg_writes = 0;
    int         settings = 1;
    logic [7:0] next_seq = '0;

    always #5 clk = ~clk;

    crc16_framed_packet_parser u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx_valid   (rx_valid),
        .rx_stall   (rx_stall),
        .rx_byte    (rx_byte),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .event_res  (event_res),
        .frame_type (frame_type),
        .frame_seq  (frame_seq),
        .frame_len  (frame_len),
        .data_valid (data_valid),
        .data_byte  (data_byte),
        .data_index (data_index),
        .gap_flag   (gap_flag),
        .seq_gap    (seq_gap),
        .last       (last),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // mostly short pauses, now and then a long one
    function automatic int idle_len();
        if ($urandom_range(0, 99) < 80)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // receiver back-pressure
    always @(posedge clk)
    begin
        if (hold_left == 0 && !quiet && $urandom_range(0, 99) < 20)
            hold_left = idle_len();
        if (hold_left > 0)
        begin
            res_stall <= 1'b1;
            hold_left--;
        end
        else
            res_stall <= 1'b0;
    end

    // transfer monitor on all three channels
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            idle_cycles++;
            if (rx_valid && !rx_stall)
            begin
                chk.take_byte(rx_byte);
                idle_cycles = 0;
            end
            if (res_valid && !res_stall)
            begin
                chk.match_result({event_res, frame_type, frame_seq, frame_len, data_valid,
                                  data_byte, data_index, gap_flag, seq_gap, last});
                idle_cycles = 0;
            end
            if (cfg_valid && cfg_ready)
                idle_cycles = 0;
        end
    end

    initial
    begin : watchdog
        while (idle_cycles < IDLE_LIMIT)
            @(negedge clk);
        $display("%0t: no transfer for %0d cycles, %0d results still due",
                 $time, IDLE_LIMIT, chk.results_due.size());
        $display("Simulation FAILED");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = (!quiet && $urandom_range(0, 99) < 30) ? idle_len() : 0;
        if (gap > 0)
        begin
            rx_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (rx_stall)
            @(posedge clk);
        bytes_sent++;
    endtask

    // fill < 0 gives random payload bytes
    task automatic send_frame(input logic [7:0] seq, input logic [7:0] ftype, input int len,
                              input frame_kind_e kind, input int fill);
        logic [7:0]  body [$];
        logic [7:0]  wire_q [$];
        logic [15:0] fcs;
        logic [7:0]  b;
        int          cut;
        wire_q.push_back(chk.sync_a);
        if (kind == FK_SYNC_RETRY)
            wire_q.push_back(chk.sync_a);
        if (kind == FK_BAD_SYNC)
        begin
            do
                b = 8'($urandom_range(0, 255));
            while (b == chk.sync_b || b == chk.sync_a);
            wire_q.push_back(b);
        end
        else
        begin
            wire_q.push_back(chk.sync_b);
            if (kind == FK_BAD_VER)
                wire_q.push_back(chk.version ^ 8'($urandom_range(1, 255)));
            else if (kind == FK_BAD_LEN)
                wire_q = {wire_q, chk.version, seq, ftype, 8'(len)};
            else
            begin
                body = {chk.version, seq, ftype, 8'(len)};
                repeat (len)
                    body.push_back(fill < 0 ? 8'($urandom_range(0, 255)) : 8'(fill));
                fcs = chk.wire_crc(body);
                if (kind == FK_BAD_CRC_LO)
                    fcs = fcs ^ (16'd1 << $urandom_range(0, 7));
                else if (kind == FK_BAD_CRC_HI)
                    fcs = fcs ^ (16'd1 << $urandom_range(8, 15));
                wire_q = {wire_q, body, fcs[7:0], fcs[15:8]};
            end
        end
        if (kind == FK_CUT)
        begin
            cut    = $urandom_range(1, wire_q.size() - 1);
            wire_q = wire_q[0:cut-1];
        end
        foreach (wire_q[i])
            send_byte(wire_q[i]);
        frames_sent++;
    endtask

    // write data is chosen by the caller; only the register width matters to the parser
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        chk.write_reg(idx, data);
        reg_writes++;
    endtask

    // upper bits of the narrow registers carry junk so that masking is exercised
    task automatic configure(input logic [7:0] sa, input logic [7:0] sb, input logic [7:0] ver,
                             input logic [15:0] poly, input logic [15:0] init,
                             input logic refl, input logic [15:0] xo);
        write_reg(cfpp_pkg::CFG_SYNC_FIRST, {8'($urandom_range(0, 255)), sa});
        write_reg(cfpp_pkg::CFG_SYNC_SECOND, {8'($urandom_range(0, 255)), sb});
        write_reg(cfpp_pkg::CFG_VERSION, {8'($urandom_range(0, 255)), ver});
        write_reg(cfpp_pkg::CFG_CRC_POLY, poly);
        write_reg(cfpp_pkg::CFG_CRC_INIT, init);
        write_reg(cfpp_pkg::CFG_CRC_REFLECT, {15'($urandom_range(0, 32767)), refl});
        write_reg(cfpp_pkg::CFG_CRC_XOROUT, xo);
        write_reg(CFG_UNUSED, 16'($urandom_range(0, 65535)));
        cfg_valid <= 1'b0;
        settings++;
    endtask

    // idle point: nothing due and the parse step finished
    task automatic settle();
        rx_valid <= 1'b0;
        // let the monitor see the last byte transfer before the due list is polled
        @(posedge clk);
        while (chk.results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(0, 8);
        if (r < 95)
            return $urandom_range(9, 24);
        return $urandom_range(25, cfpp_pkg::MAX_PAYLOAD_DEF);
    endfunction

    // mostly well-formed frames with random content, the rest broken or noise
    task automatic random_traffic(input int budget);
        int          start;
        int          r;
        frame_kind_e kind;
        logic [7:0]  seq;
        start = bytes_sent;
        while (bytes_sent - start < budget)
        begin
            quiet = ($urandom_range(0, 5) == 0);
            r     = $urandom_range(0, 99);
            seq   = ($urandom_range(0, 99) < 85) ? next_seq : 8'($urandom_range(0, 255));
            next_seq = seq + 8'd1;
            if (r >= 95)
                repeat ($urandom_range(1, 4))
                    send_byte(8'($urandom_range(0, 255)));
            else
            begin
                kind = (r < 70) ? FK_GOOD :
                       (r < 74) ? FK_BAD_CRC_LO :
                       (r < 77) ? FK_BAD_CRC_HI :
                       (r < 81) ? FK_BAD_VER :
                       (r < 85) ? FK_BAD_LEN :
                       (r < 88) ? FK_BAD_SYNC :
                       (r < 91) ? FK_SYNC_RETRY : FK_CUT;
                send_frame(seq, 8'($urandom_range(0, 255)),
                           (kind == FK_BAD_LEN) ? $urandom_range(65, 255) : pick_len(),
                           kind, -1);
            end
        end
    endtask

    initial
    begin : main_seq
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed cases on reset register values
        quiet = 1'b0;
        send_byte(8'h00);
        send_byte(8'hFF);
        send_frame(8'h00, 8'h00, 0, FK_GOOD, -1);
        send_frame(8'h01, 8'hFF, 1, FK_GOOD, 8'hFF);
        send_frame(8'h05, 8'h3C, 64, FK_GOOD, -1);
        send_frame(8'h06, 8'h11, 2, FK_GOOD, 8'h00);
        send_frame(8'hFF, 8'h22, 3, FK_GOOD, -1);
        send_frame(8'h00, 8'h33, 1, FK_GOOD, -1);
        send_frame(8'h01, 8'h44, 2, FK_BAD_CRC_LO, -1);
        send_frame(8'h02, 8'h55, 0, FK_BAD_CRC_HI, -1);
        send_frame(8'h01, 8'h66, 1, FK_GOOD, -1);
        send_frame(8'h02, 8'h00, 0, FK_BAD_VER, -1);
        send_frame(8'h02, 8'h00, 65, FK_BAD_LEN, -1);
        send_frame(8'h02, 8'h00, 255, FK_BAD_LEN, -1);
        send_frame(8'h02, 8'h00, 0, FK_BAD_SYNC, -1);
        send_frame(8'h02, 8'h77, 2, FK_SYNC_RETRY, -1);
        send_frame(8'h03, 8'h88, 4, FK_CUT, -1);
        send_frame(8'h03, 8'h99, 1, FK_GOOD, -1);
        next_seq = 8'h04;
        settle();

        random_traffic(12);
        settle();

        configure(8'h00, 8'hFF, 8'hFF, 16'h8005, 16'h0000, 1'b1, 16'h0000);
        quiet = 1'b1;
        send_frame(next_seq, 8'hA5, 5, FK_GOOD, -1);
        next_seq = next_seq + 8'd1;
        random_traffic(4);
        settle();

        configure(8'hFF, 8'h00, 8'h00, 16'hFFFF, 16'h0000, 1'b0, 16'hFFFF);
        random_traffic(4);
        settle();

        // equal sync bytes and a polynomial of zero
        configure(8'h5A, 8'h5A, 8'h80, 16'h0000, 16'($urandom_range(0, 65535)), 1'b1,
                  16'($urandom_range(0, 65535)));
        random_traffic(4);
        settle();

        configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                  16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
                  16'($urandom_range(0, 65535)));
        random_traffic(4);
        settle();
        repeat (20) @(posedge clk);

        $display("run covered %0d received bytes in %0d frames under %0d register settings",
                 bytes_sent, frames_sent, settings);
        $display("%0d results checked, %0d register writes, %0d results still due",
                 chk.checked, reg_writes, chk.results_due.size());
        if (chk.errors == 0 && chk.results_due.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
